@@ rtl/hnt_pkg.sv @@
`timescale 1ns / 1ps
// Package of the held-note tracker: types, MIDI codes and result kinds.
// Used by the tracker top level and its checker; depends on nothing.
package hnt_pkg;

    // MIDI status types (high nibble of the status byte).
    localparam logic [3:0] MIDI_NOTE_OFF  = 4'h8;
    localparam logic [3:0] MIDI_NOTE_ON   = 4'h9;
    localparam logic [3:0] MIDI_POLY_PRES = 4'hA;
    localparam logic [3:0] MIDI_CTRL      = 4'hB;
    localparam logic [3:0] MIDI_CHAN_PRES = 4'hD;
    localparam logic [3:0] MIDI_BEND      = 4'hE;

    // Controller numbers with a meaning of their own.
    localparam logic [6:0] CC_MODULATION = 7'd1;
    localparam logic [6:0] CC_EXPRESSION = 7'd11;
    localparam logic [6:0] CC_TIMBRE     = 7'd74;

    // Result kinds.
    localparam logic [2:0] KIND_NOTE_ON  = 3'd0;
    localparam logic [2:0] KIND_NOTE_OFF = 3'd1;
    localparam logic [2:0] KIND_BEND     = 3'd2;
    localparam logic [2:0] KIND_PRESSURE = 3'd3;
    localparam logic [2:0] KIND_TIMBRE   = 3'd4;
    localparam logic [2:0] KIND_SUMMARY  = 3'd5;

    // Routing modes.
    localparam logic [1:0] MODE_POLY      = 2'd0;
    localparam logic [1:0] MODE_MPE_LOWER = 2'd1;
    localparam logic [1:0] MODE_MPE_UPPER = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] REG_CHANNEL_FILTER = 2'd0;
    localparam logic [1:0] REG_ROUTE_MODE     = 2'd1;
    localparam logic [1:0] REG_CC_SELECT      = 2'd2;
    localparam logic [1:0] REG_LEARN_ENABLE   = 2'd3;

    // Bend offset toggles the top bit of the 14-bit raw value.
    localparam logic [13:0] BEND_CENTER = 14'h2000;

    // Results per input item are capped.
    localparam int          MAX_RESULTS = 16;
    localparam int          NRES_W      = 5;
    localparam int          CC_DEPTH    = 128;
    localparam int          ENTRY_W     = 44;

    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 104;

    typedef enum logic [3:0] {
        S_IDLE, S_DEC, S_RD, S_CHK, S_ADD, S_SH_RD, S_SH_WR,
        S_SUM1, S_SUM2, S_SUM3, S_FLUSH
    } t_state;

    // Kind of table walk an item asks for.
    typedef enum logic [1:0] {
        CLS_ON, CLS_OFF, CLS_FIND, CLS_PP
    } t_cls;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] voice_id;
        logic [6:0]  key;
        logic [13:0] amount;
        logic        gate;
        logic        trigger;
        logic [13:0] bend_level;
        logic [6:0]  modulation;
        logic [6:0]  cc_level;
        logic [6:0]  aftertouch;
        logic [6:0]  expression;
    } t_res;

endpackage

@@ rtl/midi_held_note_tracker.sv @@
`timescale 1ns / 1ps
// Top level of the MIDI held-note tracker: sequencer, table walk and output stage.
// Depends on hnt_pkg and hnt_ram.

// The block takes one parsed MIDI channel message or one summary request per
// input transaction and is not ready again until that item's results are
// queued. Note and expression messages walk the held-note table with one shared
// compare unit through the table RAM's registered read port, all but a note on
// of nonzero velocity in poly mode, which goes straight to the add step. A note
// off that closes a gap moves each later entry down by one. A summary makes
// two reads of the controller store, and back-pressure on the output stream
// can stall an item. Results leave through an output register with a
// one-entry holding stage in front; tlast marks the last result of an item.
// The controller store comes out of reset cleared, with no clearing pass.
module midi_held_note_tracker
    import hnt_pkg::*;
#(
    parameter int MAX_HELD = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Input stream. tdata: status_byte, data_first, data_second, byte_count.
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // tuser: op.
    input  logic                  s_axis_tuser,
    // Output stream. tdata: voice_id, key, amount, gate, trigger, bend_level,
    // modulation, cc_level, aftertouch, expression, zero fill.
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // tuser: kind.
    output logic [2:0]            m_axis_tuser,
    output logic                  m_axis_tlast,
    // Configuration write port.
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_idx,
    input  logic [6:0]            i_cfg_data
);

    localparam int CW = $clog2(MAX_HELD + 1);
    localparam int IW = (MAX_HELD > 1) ? $clog2(MAX_HELD) : 1;

    t_state r_state, n_state;

    // Configuration registers.
    logic [4:0]  r_filter;
    logic [1:0]  r_mode;
    logic [6:0]  r_cc_sel;
    logic        r_learn_en;

    // Scalar state.
    logic [CW-1:0] r_count;
    logic [31:0]   r_id;
    logic [6:0]    r_last_key, r_last_vel, r_press, r_expr, r_mod;
    logic [13:0]   r_bend;
    logic          r_seen, r_learn_done;
    logic [CC_DEPTH-1:0] r_ccv;
    logic          r_ccv_q;

    // Latched input item and walk control.
    logic          r_op;
    logic [7:0]    r_st;
    logic [6:0]    r_d1, r_d2;
    logic [1:0]    r_cnt;
    t_cls          r_cls;
    logic [2:0]    r_fkind;
    logic [13:0]   r_famt;
    logic [CW-1:0] r_idx;
    logic [NRES_W-1:0] r_nres;

    // Holding stage and output register.
    t_res          r_pend, r_out;
    logic          r_pend_v, r_ovalid, r_out_last;

    // Comb control.
    logic          w_emit, w_flush, w_add, w_idx_inc, w_cnt_dec, w_scan_start;
    t_res          w_new;
    logic          w_out_free, w_can_emit;

    // Decode of the latched item.
    logic [3:0]    w_type;
    logic [4:0]    w_ch;
    logic          w_mpe, w_member, w_pass;

    // Table RAM ports.
    logic               w_hwe;
    logic [IW-1:0]      w_hwaddr, w_hraddr;
    logic [ENTRY_W-1:0] w_hwdata, w_hrd;
    logic [6:0]         w_ekey;
    logic [4:0]         w_ech;
    logic [31:0]        w_eid;
    logic               w_key_eq, w_ch_eq;
    logic [CW-1:0]      w_idx_nx;

    // Controller store ports.
    logic               w_cwe;
    logic [6:0]         w_craddr, w_crd, w_cc_val;

    assign w_type   = r_st[7:4];
    assign w_ch     = {1'b0, r_st[3:0]} + 5'd1;
    assign w_mpe    = (r_mode == MODE_MPE_LOWER) || (r_mode == MODE_MPE_UPPER);
    assign w_member = w_mpe && (w_ch >= 5'd2) && (w_ch <= 5'd15);
    assign w_pass   = (r_filter == 5'd0) || (r_filter == w_ch);

    assign w_ekey   = w_hrd[6:0];
    assign w_ech    = w_hrd[11:7];
    assign w_eid    = w_hrd[43:12];
    assign w_key_eq = (w_ekey == r_d1);
    assign w_ch_eq  = (w_ech == w_ch);
    assign w_idx_nx = r_idx + CW'(1);

    assign w_out_free = !r_ovalid || m_axis_tready;
    assign w_can_emit = !r_pend_v || w_out_free;
    assign w_cc_val   = r_ccv_q ? w_crd : 7'd0;

    // Table RAM addressing.
    assign w_hwe    = w_add || (r_state == S_SH_WR);
    assign w_hwaddr = w_add ? r_count[IW-1:0] : r_idx[IW-1:0];
    assign w_hwdata = w_add ? {r_id + 32'd1, w_ch, r_d1} : w_hrd;
    assign w_hraddr = (r_state == S_SH_RD) ? w_idx_nx[IW-1:0] : r_idx[IW-1:0];

    hnt_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_HELD)) u_table (
        .i_clk   (i_clk),
        .i_we    (w_hwe),
        .i_waddr (w_hwaddr),
        .i_wdata (w_hwdata),
        .i_raddr (w_hraddr),
        .o_rdata (w_hrd)
    );

    // Controller store: written by every complete controller message that passes the channel filter.
    assign w_cwe    = (r_state == S_DEC) && !r_op && (r_cnt == 2'd3) && w_pass
                      && (w_type == MIDI_CTRL);
    assign w_craddr = (r_state == S_SUM1) ? CC_MODULATION : r_cc_sel;

    hnt_ram #(.WIDTH(7), .DEPTH(CC_DEPTH)) u_cc (
        .i_clk   (i_clk),
        .i_we    (w_cwe),
        .i_waddr (r_d1),
        .i_wdata (r_d2),
        .i_raddr (w_craddr),
        .o_rdata (w_crd)
    );

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and control strobes.
    always_comb begin
        n_state      = r_state;
        w_emit       = 1'b0;
        w_flush      = 1'b0;
        w_add        = 1'b0;
        w_idx_inc    = 1'b0;
        w_cnt_dec    = 1'b0;
        w_scan_start = 1'b0;
        w_new        = '0;
        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                n_state = S_IDLE;
                if (r_op) begin
                    n_state = S_SUM1;
                end else if (r_cnt != 2'd0 && w_pass) begin
                    if (w_type == MIDI_NOTE_ON && r_cnt == 2'd3) begin
                        w_scan_start = 1'b1;
                        if (r_d2 != 7'd0 && !w_mpe) begin
                            n_state = S_ADD;
                        end else begin
                            n_state = S_RD;
                        end
                    end else if (w_type == MIDI_NOTE_OFF && r_cnt == 2'd3) begin
                        w_scan_start = 1'b1;
                        n_state      = S_RD;
                    end else if (w_type == MIDI_CTRL && r_cnt == 2'd3) begin
                        if (r_d1 == CC_TIMBRE && w_member) begin
                            w_scan_start = 1'b1;
                            n_state      = S_RD;
                        end
                    end else if (w_type == MIDI_BEND && r_cnt == 2'd3) begin
                        if (w_member) begin
                            w_scan_start = 1'b1;
                            n_state      = S_RD;
                        end
                    end else if (w_type == MIDI_CHAN_PRES && r_cnt >= 2'd2) begin
                        if (w_member) begin
                            w_scan_start = 1'b1;
                            n_state      = S_RD;
                        end
                    end else if (w_type == MIDI_POLY_PRES && r_cnt == 2'd3) begin
                        w_scan_start = 1'b1;
                        n_state      = S_RD;
                    end
                end
            end
            S_RD: begin
                if (r_idx >= r_count) begin
                    n_state = (r_cls == CLS_ON) ? S_ADD : S_FLUSH;
                end else begin
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                w_new.voice_id = w_eid;
                case (r_cls)
                    CLS_ON: begin
                        if (w_key_eq && w_ch_eq) begin
                            n_state = S_FLUSH;
                        end else begin
                            w_idx_inc = 1'b1;
                            n_state   = S_RD;
                        end
                    end
                    CLS_OFF: begin
                        w_new.kind = KIND_NOTE_OFF;
                        w_new.key  = r_d1;
                        if (w_key_eq && (!w_mpe || w_ch_eq)) begin
                            if (w_can_emit) begin
                                w_emit  = 1'b1;
                                n_state = S_SH_RD;
                            end
                        end else begin
                            w_idx_inc = 1'b1;
                            n_state   = S_RD;
                        end
                    end
                    CLS_FIND: begin
                        w_new.kind   = r_fkind;
                        w_new.key    = w_ekey;
                        w_new.amount = r_famt;
                        if (w_ch_eq) begin
                            if (w_can_emit) begin
                                w_emit  = 1'b1;
                                n_state = S_FLUSH;
                            end
                        end else begin
                            w_idx_inc = 1'b1;
                            n_state   = S_RD;
                        end
                    end
                    CLS_PP: begin
                        w_new.kind   = KIND_PRESSURE;
                        w_new.key    = r_d1;
                        w_new.amount = {7'd0, r_d2};
                        if (w_key_eq && (!w_mpe || w_ch_eq)) begin
                            if (r_nres >= NRES_W'(MAX_RESULTS) || w_can_emit) begin
                                w_emit = (r_nres < NRES_W'(MAX_RESULTS));
                                if (w_mpe) begin
                                    n_state = S_FLUSH;
                                end else begin
                                    w_idx_inc = 1'b1;
                                    n_state   = S_RD;
                                end
                            end
                        end else begin
                            w_idx_inc = 1'b1;
                            n_state   = S_RD;
                        end
                    end
                    default: n_state = S_FLUSH;
                endcase
            end
            S_ADD: begin
                w_new.kind     = KIND_NOTE_ON;
                w_new.voice_id = r_id + 32'd1;
                w_new.key      = r_d1;
                w_new.amount   = {7'd0, r_d2};
                if (r_count < CW'(MAX_HELD)) begin
                    if (w_can_emit) begin
                        w_add   = 1'b1;
                        w_emit  = 1'b1;
                        n_state = S_FLUSH;
                    end
                end else begin
                    n_state = S_FLUSH;
                end
            end
            S_SH_RD: begin
                if (w_idx_nx < r_count) begin
                    n_state = S_SH_WR;
                end else begin
                    w_cnt_dec = 1'b1;
                    n_state   = S_FLUSH;
                end
            end
            S_SH_WR: begin
                w_idx_inc = 1'b1;
                n_state   = S_SH_RD;
            end
            S_SUM1: n_state = S_SUM2;
            S_SUM2: n_state = S_SUM3;
            S_SUM3: begin
                w_new.kind       = KIND_SUMMARY;
                w_new.key        = r_last_key;
                w_new.amount     = {7'd0, r_last_vel};
                w_new.gate       = (r_count != '0);
                w_new.trigger    = r_seen;
                w_new.bend_level = r_bend;
                w_new.modulation = r_mod;
                w_new.cc_level   = w_cc_val;
                w_new.aftertouch = r_press;
                w_new.expression = r_expr;
                w_emit           = 1'b1;
                n_state          = S_FLUSH;
            end
            S_FLUSH: begin
                if (!r_pend_v) begin
                    n_state = S_IDLE;
                end else if (w_out_free) begin
                    w_flush = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control and scalar state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter     <= '0;
            r_mode       <= MODE_POLY;
            r_cc_sel     <= CC_MODULATION;
            r_learn_en   <= 1'b0;
            r_learn_done <= 1'b0;
            r_count      <= '0;
            r_id         <= '0;
            r_last_key   <= '0;
            r_last_vel   <= '0;
            r_bend       <= '0;
            r_press      <= '0;
            r_expr       <= '0;
            r_seen       <= 1'b0;
            r_ccv        <= '0;
            r_pend_v     <= 1'b0;
            r_ovalid     <= 1'b0;
            r_nres       <= '0;
            r_idx        <= '0;
        end else begin
            // Item state; the learn capture runs only while an item is decoded.
            if (r_state == S_DEC && !r_op && r_cnt != 2'd0 && w_pass) begin
                if (w_type == MIDI_NOTE_ON && r_cnt == 2'd3 && r_d2 != 7'd0) begin
                    r_last_key <= r_d1;
                    r_last_vel <= r_d2;
                    r_seen     <= 1'b1;
                end
                if (w_type == MIDI_CTRL && r_cnt == 2'd3) begin
                    r_ccv[r_d1] <= 1'b1;
                    if (r_learn_en && !r_learn_done) begin
                        r_cc_sel     <= r_d1;
                        r_learn_done <= 1'b1;
                    end
                    if (r_d1 == CC_EXPRESSION) begin
                        r_expr <= r_d2;
                    end
                end
                if (w_type == MIDI_BEND && r_cnt == 2'd3) begin
                    r_bend <= {r_d2, r_d1} ^ BEND_CENTER;
                end
                if (w_type == MIDI_CHAN_PRES && r_cnt >= 2'd2) begin
                    r_press <= r_d1;
                end
            end

            // Configuration writes must arrive only while idle; the block itself does not enforce it.
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_CHANNEL_FILTER: r_filter <= i_cfg_data[4:0];
                    REG_ROUTE_MODE:     r_mode   <= i_cfg_data[1:0];
                    REG_CC_SELECT:      r_cc_sel <= i_cfg_data;
                    REG_LEARN_ENABLE: begin
                        r_learn_en   <= i_cfg_data[0];
                        r_learn_done <= 1'b0;
                    end
                    default: r_filter <= r_filter;
                endcase
            end

            if (s_axis_tvalid && s_axis_tready) begin
                r_nres <= '0;
            end
            if (w_scan_start) begin
                r_idx <= '0;
            end
            if (w_idx_inc) begin
                r_idx <= w_idx_nx;
            end
            if (w_add) begin
                r_count <= r_count + CW'(1);
                r_id    <= r_id + 32'd1;
            end
            if (w_cnt_dec) begin
                r_count <= r_count - CW'(1);
            end
            if (r_state == S_SUM3) begin
                r_seen <= 1'b0;
            end

            // A new result pushes the held one out, not yet marked last; the
            // output register drains on a completed transaction otherwise.
            if (w_flush || (w_emit && r_pend_v)) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            if (w_emit) begin
                r_pend_v <= 1'b1;
                r_nres   <= r_nres + NRES_W'(1);
            end
            if (w_flush) begin
                r_pend_v <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_op  <= s_axis_tuser;
            r_st  <= s_axis_tdata[7:0];
            r_d1  <= s_axis_tdata[14:8];
            r_d2  <= s_axis_tdata[21:15];
            r_cnt <= s_axis_tdata[23:22];
        end
        if (r_state == S_DEC) begin
            if (w_type == MIDI_NOTE_ON) begin
                r_cls <= (r_d2 != 7'd0) ? CLS_ON : CLS_OFF;
            end else if (w_type == MIDI_NOTE_OFF) begin
                r_cls <= CLS_OFF;
            end else if (w_type == MIDI_POLY_PRES) begin
                r_cls <= CLS_PP;
            end else begin
                r_cls <= CLS_FIND;
            end
            if (w_type == MIDI_BEND) begin
                r_fkind <= KIND_BEND;
                r_famt  <= {r_d2, r_d1} ^ BEND_CENTER;
            end else if (w_type == MIDI_CHAN_PRES) begin
                r_fkind <= KIND_PRESSURE;
                r_famt  <= {7'd0, r_d1};
            end else begin
                r_fkind <= KIND_TIMBRE;
                r_famt  <= {7'd0, r_d2};
            end
        end
        r_ccv_q <= r_ccv[w_craddr];
        if (r_state == S_SUM2) begin
            r_mod <= w_cc_val;
        end
        if (w_emit) begin
            r_pend <= w_new;
            if (r_pend_v) begin
                r_out      <= r_pend;
                r_out_last <= 1'b0;
            end
        end
        if (w_flush) begin
            r_out      <= r_pend;
            r_out_last <= 1'b1;
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tuser  = r_out.kind;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tdata  = {7'd0, r_out.expression, r_out.aftertouch, r_out.cc_level,
                            r_out.modulation, r_out.bend_level, r_out.trigger, r_out.gate,
                            r_out.amount, r_out.key, r_out.voice_id};

endmodule

@@ rtl/hnt_ram.sv @@
`timescale 1ns / 1ps
// Generic simple dual-port RAM with one write port and a registered read.
// Stand-alone; used for the held-note table and the controller store.
module hnt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/hnt_chk.sv @@
`timescale 1ns / 1ps
// Port-level checker of the held-note tracker, bound to the top level.
// Depends on hnt_pkg for the result kinds and stream widths.
module hnt_chk
    import hnt_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata,
    input logic [2:0]            m_axis_tuser,
    input logic                  m_axis_tlast
);

    // A stalled result holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // The block works on one item at a time.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while an item is in work");

    // A summary is always the only and last result of its item.
    a_sum_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == KIND_SUMMARY |-> m_axis_tlast)
        else $error("summary without tlast");

    // Summary levels are zero in note events.
    a_sum_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != KIND_SUMMARY |-> m_axis_tdata[96:53] == '0)
        else $error("summary fields set in a note event");

    // Reset empties the output register.
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind midi_held_note_tracker hnt_chk u_hnt_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
